FILE: rtl/qte_pkg.sv
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int TAB_LEN = 24;

  // CORDIC datapath width: operands up to 2^35 * 2^16 * gain
  localparam int CW = 56;
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] DEG90 = 34'sd754974720;

  localparam logic [0:0] REG_DECLINATION = 1'b0;
  localparam logic [0:0] REG_YAW_OFFSET  = 1'b1;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (i)
      0: v = 34'sd377487360;  1: v = 34'sd222843801;  2: v = 34'sd117744544;
      3: v = 34'sd59768969;   4: v = 34'sd30000467;   5: v = 34'sd15014858;
      6: v = 34'sd7509261;    7: v = 34'sd3754860;    8: v = 34'sd1877459;
      9: v = 34'sd938733;     10: v = 34'sd469367;    11: v = 34'sd234683;
      12: v = 34'sd117342;    13: v = 34'sd58671;     14: v = 34'sd29335;
      15: v = 34'sd14668;     16: v = 34'sd7334;      17: v = 34'sd3667;
      18: v = 34'sd1833;      19: v = 34'sd917;       20: v = 34'sd458;
      21: v = 34'sd229;       22: v = 34'sd115;       23: v = 34'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

endpackage
`default_nettype wire

FILE: rtl/qte_cordic.sv
`default_nettype none
module qte_cordic (
  input  wire logic                     clk,
  input  wire logic                     en_in,
  input  wire logic signed [qte_pkg::CW-1:0] x_in,
  input  wire logic signed [qte_pkg::CW-1:0] y_in,
  output logic signed [qte_pkg::ZW-1:0] z_out
);
  import qte_pkg::*;

  localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  cvec_t pre;
  cvec_t st [NS+1];
  logic  zero_in;

  // Prerotate into the right half plane; scale by 2^16.
  always_comb begin
    logic signed [CW-1:0] xs, ys;
    xs = x_in <<< 16;
    ys = y_in <<< 16;
    zero_in = (x_in == '0) && (y_in == '0);
    pre.x = xs;
    pre.y = ys;
    pre.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        pre.x = ys; pre.y = -xs; pre.z = DEG90;
      end else begin
        pre.x = -ys; pre.y = xs; pre.z = -DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_in) st[0] <= pre;
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en_in) begin
        if (st[i].y >= 0) begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + atan_tab(i);
        end else begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - atan_tab(i);
        end
      end
    end
  end

  // Zero flag travels alongside.
  logic [NS:0] zf;
  always_ff @(posedge clk) begin
    if (en_in) zf <= {zf[NS-1:0], zero_in};
  end

  assign z_out = zf[NS] ? '0 : st[NS].z;
endmodule
`default_nettype wire

FILE: rtl/quaternion_to_euler_heading_top.sv
`default_nettype none
// Quaternion to yaw/pitch/roll, 1/128 degree units.
// Input: pulse start with quat_w..quat_z; busy is always low, so a new
// quaternion is taken every cycle. Results come out on yaw_angle,
// pitch_angle, roll_angle, pitch_clamped with done high for one cycle,
// in input order.
// Pipeline: 4 product/setup stages, a pitch square-root stage chain of
// 31 stages, then the CORDIC (17 stages) and 2 output stages; all three
// angles are aligned to the longest path (pitch). Throughput is one
// item per cycle, set by the fully pipelined CORDIC and root units.
// Config: wr_en/wr_index/wr_data write declination (0) or
// yaw_zero_offset (1); other indices are dropped. Write only when idle.
// Reset: rst clears valid bits and both registers.
// The receiver cannot stall; done is a one-cycle strobe.
module quaternion_to_euler_heading_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic               wr_en,
  input  wire logic               wr_index,
  input  wire logic [16:0]        wr_data,
  output logic                    done,
  output logic signed [17:0]      yaw_angle,
  output logic signed [14:0]      pitch_angle,
  output logic signed [15:0]      roll_angle,
  output logic                    pitch_clamped
);
  import qte_pkg::*;

  localparam int SQ = 31;  // root bits, one per stage
  localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
  localparam int FB2 = 2 * QUAT_FRAC_BITS;
  localparam int LAT = 4 + SQ + (NS + 1) + 2;

  logic signed [15:0] declination;
  logic signed [16:0] yaw_zero_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= '0;
      yaw_zero_offset <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DECLINATION: declination <= wr_data[15:0];
        REG_YAW_OFFSET:  yaw_zero_offset <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end

  // Stage 1: products
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_wx, p_yz;
  always_ff @(posedge clk) begin
    p_ww <= quat_w * quat_w; p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y; p_zz <= quat_z * quat_z;
    p_xy <= quat_x * quat_y; p_wz <= quat_w * quat_z;
    p_xz <= quat_x * quat_z; p_wy <= quat_w * quat_y;
    p_wx <= quat_w * quat_x; p_yz <= quat_y * quat_z;
  end

  // Stage 2: sums
  logic signed [34:0] ys2, yc2, ps2, rs2, rc2;
  always_ff @(posedge clk) begin
    ys2 <= 35'(p_xy) + 35'(p_wz) <<< 1;
    yc2 <= 35'(p_ww) + 35'(p_xx) - 35'(p_yy) - 35'(p_zz);
    ps2 <= (35'(p_xz) - 35'(p_wy)) <<< 1;
    rs2 <= (35'(p_wx) + 35'(p_yz)) <<< 1;
    rc2 <= 35'(p_ww) - 35'(p_xx) - 35'(p_yy) + 35'(p_zz);
  end

  // Stage 3: clamp and rescale asin argument to 1.0 = 2^30
  localparam logic signed [34:0] ONE = 35'sd1 <<< FB2;
  logic signed [31:0] as3;
  logic               cl3;
  logic signed [34:0] ys3, yc3, rs3, rc3;
  always_ff @(posedge clk) begin
    logic signed [34:0] pc;
    logic signed [63:0] sc;
    pc = ps2;
    cl3 <= 1'b0;
    if (ps2 > ONE) begin pc = ONE; cl3 <= 1'b1; end
    else if (ps2 < -ONE) begin pc = -ONE; cl3 <= 1'b1; end
    if (FB2 <= 30) sc = 64'(pc) <<< (30 - FB2);
    else sc = 64'(pc) >>> (FB2 - 30);
    if (sc > 64'sd1073741824) sc = 64'sd1073741824;
    else if (sc < -64'sd1073741824) sc = -64'sd1073741824;
    as3 <= 32'(sc);
    ys3 <= ys2; yc3 <= yc2; rs3 <= rs2; rc3 <= rc2;
  end

  // Stage 4: radicand 2^60 - a^2 (|a| <= 2^30, multiply kept 31x31)
  logic [60:0] rad4;
  logic signed [31:0] as4;
  logic signed [34:0] ys4, yc4, rs4, rc4;
  logic               cl4;
  always_ff @(posedge clk) begin
    logic [30:0] m;
    m = as3[31] ? 31'(-as3) : 31'(as3);
    rad4 <= (61'd1 << 60) - 61'(m * m);
    as4 <= as3;
    ys4 <= ys3; yc4 <= yc3; rs4 <= rs3; rc4 <= rc3;
    cl4 <= cl3;
  end

  // Square root: one result bit per stage
  logic [61:0] sn [SQ+1];
  logic [61:0] sr [SQ+1];
  logic signed [31:0] sa [SQ+1];
  always_comb begin
    sn[0] = 62'(rad4);
    sr[0] = '0;
    sa[0] = as4;
  end
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQ - 1 - k));
    always_ff @(posedge clk) begin
      if (sn[k] >= sr[k] + BIT) begin
        sn[k+1] <= sn[k] - (sr[k] + BIT);
        sr[k+1] <= (sr[k] >> 1) + BIT;
      end else begin
        sn[k+1] <= sn[k];
        sr[k+1] <= sr[k] >> 1;
      end
      sa[k+1] <= sa[k];
    end
  end

  // Delay yaw/roll terms across the root chain, and the clamp flag across the root chain and CORDIC
  logic signed [34:0] dys [SQ+1], dyc [SQ+1], drs [SQ+1], drc [SQ+1];
  logic dcl [SQ+1+NS+1];
  always_comb begin
    dys[0] = ys4; dyc[0] = yc4; drs[0] = rs4; drc[0] = rc4;
  end
  always_ff @(posedge clk) begin
    dcl[0] <= cl4;
    for (int k = 0; k < SQ+NS+1; k++) dcl[k+1] <= dcl[k];
  end
  for (genvar k = 0; k < SQ; k++) begin : g_dly
    always_ff @(posedge clk) begin
      dys[k+1] <= dys[k]; dyc[k+1] <= dyc[k];
      drs[k+1] <= drs[k]; drc[k+1] <= drc[k];
    end
  end

  logic signed [ZW-1:0] zy, zp, zr;
  qte_cordic u_yaw (.clk(clk), .en_in(1'b1), .x_in(CW'(dyc[SQ])),
    .y_in(CW'(dys[SQ])), .z_out(zy));
  qte_cordic u_pitch (.clk(clk), .en_in(1'b1), .x_in(CW'(sr[SQ])),
    .y_in(CW'(sa[SQ])), .z_out(zp));
  qte_cordic u_roll (.clk(clk), .en_in(1'b1), .x_in(CW'(drc[SQ])),
    .y_in(CW'(drs[SQ])), .z_out(zr));

  // Output stage A: round and saturate
  logic signed [18:0] yu, pu, ru;
  always_ff @(posedge clk) begin
    logic signed [ZW:0] t;
    t = ((ZW+1)'(zy) + 32768) >>> 16;
    yu <= (t > 23040) ? 19'sd23040 : (t < -23040) ? -19'sd23040 : 19'(t);
    t = (-(ZW+1)'(zp) + 32768) >>> 16;
    pu <= (t > 11520) ? 19'sd11520 : (t < -11520) ? -19'sd11520 : 19'(t);
    t = ((ZW+1)'(zr) + 32768) >>> 16;
    ru <= (t > 23040) ? 19'sd23040 : (t < -23040) ? -19'sd23040 : 19'(t);
  end

  // Output stage B: declination, wrap, offset, yaw clamp
  always_ff @(posedge clk) begin
    logic signed [19:0] yv;
    yv = 20'(yu) + 20'(declination);
    if (yv < 0) yv = yv + 20'sd46080;
    yv = yv - 20'(yaw_zero_offset);
    if (yv > 20'sd92160) yv = 20'sd92160;
    else if (yv < -20'sd92160) yv = -20'sd92160;
    yaw_angle <= 18'(yv);
    pitch_angle <= 15'(pu);
    roll_angle <= 16'(ru);
    pitch_clamped <= dcl[SQ+NS+1];
  end

  assign done = vld[LAT-1];

  a_pitch_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= 15'sd11520 && pitch_angle >= -15'sd11520))
    else $error("pitch out of range");
  a_roll_rng: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040))
    else $error("roll out of range");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy set");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    vld[LAT-2] |=> done) else $error("done lost");
endmodule
`default_nettype wire
